// ----- sv/assert_macros.svh -----
// Assertion macros shared by the flow key index RTL.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SFK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define SFK_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);
`else
`define SFK_ASSERT(label, prop, msg)
`define SFK_NEVER(label, expr, msg)
`endif
`endif

// ----- sv/sfk_pkg.sv -----
// Package for the sorted flow key range index.
// Holds command and status codes, column codes, field widths and the lane control struct.
package sfk_pkg;

    localparam int CMD_W  = 2;
    localparam int ST_W   = 2;
    localparam int COL_W  = 2;
    localparam int KEY_W  = 32;
    localparam int PORT_W = 16;
    localparam int IDX_W  = 7;
    localparam int NUM_COLS = 4;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
    localparam logic [ST_W-1:0] ST_NOMATCH  = 2'd2;
    localparam logic [ST_W-1:0] ST_INVERTED = 2'd3;

    localparam logic [COL_W-1:0] COL_SRC_ADDR = 2'd0;
    localparam logic [COL_W-1:0] COL_DST_ADDR = 2'd1;
    localparam logic [COL_W-1:0] COL_SRC_PORT = 2'd2;
    localparam logic [COL_W-1:0] COL_DST_PORT = 2'd3;

    typedef struct packed {
        logic insert;
        logic capture;
    } t_lane_ctrl;

endpackage

// ----- sv/sfk_lane.sv -----
// One sorted key column: a row of cells that compare against the operands in parallel.
// Depends on sfk_pkg for the lane control struct and key width.
module sfk_lane #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                          i_clk,
    input  sfk_pkg::t_lane_ctrl           i_ctrl,
    input  logic [$clog2(DEPTH+1)-1:0]    i_count,
    input  logic [WIDTH-1:0]              i_key,
    input  logic [sfk_pkg::KEY_W-1:0]     i_lo,
    input  logic [sfk_pkg::KEY_W-1:0]     i_hi,
    output logic [DEPTH-1:0]              o_lt,
    output logic [DEPTH-1:0]              o_le
);

    logic [WIDTH-1:0]          r_cell [DEPTH];
    logic [WIDTH-1:0]          n_cell [DEPTH];
    logic [DEPTH-1:0]          lt;
    logic [DEPTH-1:0]          le;
    logic [DEPTH-1:0]          r_lt;
    logic [DEPTH-1:0]          r_le;
    logic [sfk_pkg::KEY_W-1:0] op_hi;

    assign op_hi = i_ctrl.insert ? sfk_pkg::KEY_W'(i_key) : i_hi;

    // Only cells below the entry count take part; the stored keys are sorted,
    // so both vectors are runs of ones starting at cell zero.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            lt[i] = (i < int'(i_count)) && (sfk_pkg::KEY_W'(r_cell[i]) < i_lo);
            le[i] = (i < int'(i_count)) && (sfk_pkg::KEY_W'(r_cell[i]) <= op_hi);
        end
    end

    // The new key lands just past the last cell at or below it; cells above shift up.
    always_comb begin
        n_cell[0] = le[0] ? r_cell[0] : i_key;
        for (int i = 1; i < DEPTH; i++) begin
            if (le[i]) begin
                n_cell[i] = r_cell[i];
            end else if (le[i-1]) begin
                n_cell[i] = i_key;
            end else begin
                n_cell[i] = r_cell[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.insert) begin
            r_cell <= n_cell;
        end
        if (i_ctrl.capture) begin
            r_lt <= lt;
            r_le <= le;
        end
    end

    assign o_lt = r_lt;
    assign o_le = r_le;

endmodule

// ----- sv/sfk_merge.sv -----
// Merge stage: picks the queried column, turns its compare runs into counts, forms status.
// Depends on sfk_pkg for command, status and width constants.
module sfk_merge #(
    parameter int DEPTH = 64
) (
    input  logic [sfk_pkg::CMD_W-1:0]                i_cmd,
    input  logic [sfk_pkg::COL_W-1:0]                i_column,
    input  logic [sfk_pkg::KEY_W-1:0]                i_min,
    input  logic [sfk_pkg::KEY_W-1:0]                i_max,
    input  logic                                     i_full,
    input  logic [$clog2(DEPTH+1)-1:0]               i_count,
    input  logic [sfk_pkg::NUM_COLS-1:0][DEPTH-1:0]  i_lt,
    input  logic [sfk_pkg::NUM_COLS-1:0][DEPTH-1:0]  i_le,
    output logic [sfk_pkg::ST_W-1:0]                 o_status,
    output logic [sfk_pkg::IDX_W-1:0]                o_first,
    output logic [sfk_pkg::IDX_W-1:0]                o_end
);

    localparam int CW = $clog2(DEPTH+1);

    logic [DEPTH-1:0] sel_lt;
    logic [DEPTH-1:0] sel_le;
    logic [DEPTH:0]   ext_lt;
    logic [DEPTH:0]   ext_le;
    logic [CW-1:0]    lo_cnt;
    logic [CW-1:0]    hi_cnt;

    assign sel_lt = i_lt[i_column];
    assign sel_le = i_le[i_column];
    assign ext_lt = {1'b0, sel_lt};
    assign ext_le = {1'b0, sel_le};

    // A run of ones has at most one cell where it ends; OR together the counts
    // that each possible end point stands for.
    always_comb begin
        lo_cnt = '0;
        hi_cnt = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (ext_lt[i] && !ext_lt[i+1]) begin
                lo_cnt = lo_cnt | CW'(i + 1);
            end
            if (ext_le[i] && !ext_le[i+1]) begin
                hi_cnt = hi_cnt | CW'(i + 1);
            end
        end
    end

    always_comb begin
        o_status = sfk_pkg::ST_OK;
        o_first  = sfk_pkg::IDX_W'(i_count);
        o_end    = sfk_pkg::IDX_W'(i_count);
        unique case (i_cmd)
            sfk_pkg::CMD_INSERT: begin
                if (i_full) begin
                    o_status = sfk_pkg::ST_FULL;
                end
            end
            sfk_pkg::CMD_CLEAR: begin
                o_first = '0;
                o_end   = '0;
            end
            sfk_pkg::CMD_QUERY: begin
                if (i_min > i_max) begin
                    o_status = sfk_pkg::ST_INVERTED;
                    o_first  = '0;
                    o_end    = '0;
                end else begin
                    o_first = sfk_pkg::IDX_W'(lo_cnt);
                    o_end   = sfk_pkg::IDX_W'(hi_cnt);
                    if (lo_cnt == hi_cnt) begin
                        o_status = sfk_pkg::ST_NOMATCH;
                    end
                end
            end
            default: begin
                o_status = sfk_pkg::ST_OK;
            end
        endcase
    end

endmodule

// ----- sv/sorted_flow_key_range_index.sv -----
// Channel | direction | handshake                  | payload
// input   | in        | i_in_valid / o_in_ready    | i_cmd, keys, i_query_column, range
// result  | out       | o_out_valid / i_out_ready  | o_status, o_first_index, o_end_index
// Each transaction passes through accept, compare in all four column lanes, then merge.
// A new transaction is accepted only after the last one has left merge.
// Reset clears the entry count and the control state; key cells are not cleared.
// The merge cycle waits while the output register still holds an untaken result.
`include "assert_macros.svh"
module sorted_flow_key_range_index #(
    parameter int DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [sfk_pkg::CMD_W-1:0]         i_cmd,
    input  logic [sfk_pkg::KEY_W-1:0]         i_src_addr,
    input  logic [sfk_pkg::KEY_W-1:0]         i_dst_addr,
    input  logic [sfk_pkg::PORT_W-1:0]        i_src_port,
    input  logic [sfk_pkg::PORT_W-1:0]        i_dst_port,
    input  logic [sfk_pkg::COL_W-1:0]         i_query_column,
    input  logic [sfk_pkg::KEY_W-1:0]         i_min_value,
    input  logic [sfk_pkg::KEY_W-1:0]         i_max_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [sfk_pkg::ST_W-1:0]          o_status,
    output logic [sfk_pkg::IDX_W-1:0]         o_first_index,
    output logic [sfk_pkg::IDX_W-1:0]         o_end_index
);

    localparam int CW = $clog2(DEPTH+1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CMP   = 2'd1;
    localparam logic [1:0] S_MERGE = 2'd2;

    logic [1:0]                  r_state;
    logic [1:0]                  n_state;
    logic [CW-1:0]               r_count;
    logic                        r_full;
    logic [sfk_pkg::CMD_W-1:0]   r_cmd;
    logic [sfk_pkg::KEY_W-1:0]   r_src_addr;
    logic [sfk_pkg::KEY_W-1:0]   r_dst_addr;
    logic [sfk_pkg::PORT_W-1:0]  r_src_port;
    logic [sfk_pkg::PORT_W-1:0]  r_dst_port;
    logic [sfk_pkg::COL_W-1:0]   r_column;
    logic [sfk_pkg::KEY_W-1:0]   r_min;
    logic [sfk_pkg::KEY_W-1:0]   r_max;
    logic                        r_out_valid;
    logic [sfk_pkg::ST_W-1:0]    r_status;
    logic [sfk_pkg::IDX_W-1:0]   r_first;
    logic [sfk_pkg::IDX_W-1:0]   r_end;

    logic                        in_fire;
    logic                        has_room;
    logic                        out_load;
    sfk_pkg::t_lane_ctrl         lane_ctrl;
    logic [sfk_pkg::NUM_COLS-1:0][DEPTH-1:0] lane_lt;
    logic [sfk_pkg::NUM_COLS-1:0][DEPTH-1:0] lane_le;
    logic [sfk_pkg::ST_W-1:0]    m_status;
    logic [sfk_pkg::IDX_W-1:0]   m_first;
    logic [sfk_pkg::IDX_W-1:0]   m_end;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign has_room   = (r_count < CW'(DEPTH));
    assign out_load   = (r_state == S_MERGE) && (!r_out_valid || i_out_ready);

    assign lane_ctrl.capture = (r_state == S_CMP);
    assign lane_ctrl.insert  = (r_state == S_CMP) && (r_cmd == sfk_pkg::CMD_INSERT) && has_room;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_fire) n_state = S_CMP;
            S_CMP:   n_state = S_MERGE;
            S_MERGE: if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CMP) begin
                if (lane_ctrl.insert) begin
                    r_count <= r_count + 1'b1;
                end else if (r_cmd == sfk_pkg::CMD_CLEAR) begin
                    r_count <= '0;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd      <= i_cmd;
            r_src_addr <= i_src_addr;
            r_dst_addr <= i_dst_addr;
            r_src_port <= i_src_port;
            r_dst_port <= i_dst_port;
            r_column   <= i_query_column;
            r_min      <= i_min_value;
            r_max      <= i_max_value;
        end
        if (r_state == S_CMP) begin
            r_full <= !has_room;
        end
        if (out_load) begin
            r_status <= m_status;
            r_first  <= m_first;
            r_end    <= m_end;
        end
    end

    // Lane order follows the column codes so the merge can index by column.
    sfk_lane #(.DEPTH(DEPTH), .WIDTH(sfk_pkg::KEY_W)) u_lane_src_addr (
        .i_clk  (i_clk),
        .i_ctrl (lane_ctrl),
        .i_count(r_count),
        .i_key  (r_src_addr),
        .i_lo   (r_min),
        .i_hi   (r_max),
        .o_lt   (lane_lt[sfk_pkg::COL_SRC_ADDR]),
        .o_le   (lane_le[sfk_pkg::COL_SRC_ADDR])
    );

    sfk_lane #(.DEPTH(DEPTH), .WIDTH(sfk_pkg::KEY_W)) u_lane_dst_addr (
        .i_clk  (i_clk),
        .i_ctrl (lane_ctrl),
        .i_count(r_count),
        .i_key  (r_dst_addr),
        .i_lo   (r_min),
        .i_hi   (r_max),
        .o_lt   (lane_lt[sfk_pkg::COL_DST_ADDR]),
        .o_le   (lane_le[sfk_pkg::COL_DST_ADDR])
    );

    sfk_lane #(.DEPTH(DEPTH), .WIDTH(sfk_pkg::PORT_W)) u_lane_src_port (
        .i_clk  (i_clk),
        .i_ctrl (lane_ctrl),
        .i_count(r_count),
        .i_key  (r_src_port),
        .i_lo   (r_min),
        .i_hi   (r_max),
        .o_lt   (lane_lt[sfk_pkg::COL_SRC_PORT]),
        .o_le   (lane_le[sfk_pkg::COL_SRC_PORT])
    );

    sfk_lane #(.DEPTH(DEPTH), .WIDTH(sfk_pkg::PORT_W)) u_lane_dst_port (
        .i_clk  (i_clk),
        .i_ctrl (lane_ctrl),
        .i_count(r_count),
        .i_key  (r_dst_port),
        .i_lo   (r_min),
        .i_hi   (r_max),
        .o_lt   (lane_lt[sfk_pkg::COL_DST_PORT]),
        .o_le   (lane_le[sfk_pkg::COL_DST_PORT])
    );

    sfk_merge #(.DEPTH(DEPTH)) u_merge (
        .i_cmd   (r_cmd),
        .i_column(r_column),
        .i_min   (r_min),
        .i_max   (r_max),
        .i_full  (r_full),
        .i_count (r_count),
        .i_lt    (lane_lt),
        .i_le    (lane_le),
        .o_status(m_status),
        .o_first (m_first),
        .o_end   (m_end)
    );

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_first_index = r_first;
    assign o_end_index   = r_end;

    `SFK_NEVER(a_count_range, r_count > CW'(DEPTH), "entry count exceeds table depth")
    `SFK_ASSERT(a_accept_starts, in_fire |=> r_state == S_CMP, "accepted transaction did not enter compare")
    `SFK_ASSERT(a_result_source, $rose(r_out_valid) |-> $past(r_state) == S_MERGE, "result raised outside merge")
    `SFK_ASSERT(a_insert_counts, lane_ctrl.insert |=> r_count == $past(r_count) + 1'b1, "insert did not advance count")
    `SFK_ASSERT(a_clear_empties, (r_state == S_CMP && r_cmd == sfk_pkg::CMD_CLEAR) |=> r_count == '0, "clear left entries")

endmodule
